// ===== rtl/cau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, operation codes and the control word that travels with
// each item through the complex arithmetic pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DataWidthDef = 16;
   localparam int FracBitsDef  = 8;
   localparam int CmdWidth     = 3;

   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_EQ  = 3'd4,
      CMD_NE  = 3'd5
   } cmd_type;

   typedef struct packed {
      logic is_div;
      logic div_zero;
      logic neg_re;
      logic neg_im;
      logic ovf_re;
      logic ovf_im;
      logic saturated;
      logic compare_true;
   } ctl_type;

endpackage
`default_nettype wire

// ===== rtl/cau_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Three register stages: partial products, sums, then scaling/saturation of
// the simple results and operand preparation for the divider.
// ----------------------------------------------------------------------------
module cau_front
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = DataWidthDef,
   parameter int FRAC_BITS  = FracBitsDef,
   localparam int NumWidth  = 2*DATA_WIDTH+1+FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [CmdWidth-1:0]          cmd,
   input  logic signed [DATA_WIDTH-1:0] a_re,
   input  logic signed [DATA_WIDTH-1:0] a_im,
   input  logic signed [DATA_WIDTH-1:0] b_re,
   input  logic signed [DATA_WIDTH-1:0] b_im,
   output logic                         out_valid,
   output ctl_type                      out_ctl,
   output logic [DATA_WIDTH-1:0]        out_re,
   output logic [DATA_WIDTH-1:0]        out_im,
   output logic [NumWidth-1:0]          out_num_re,
   output logic [NumWidth-1:0]          out_num_im,
   output logic [2*DATA_WIDTH-1:0]      out_den
);

   localparam int W = DATA_WIDTH;

   function automatic logic [W:0] clip_fn(input logic signed [2*W:0] v);
      logic signed [2*W:0] hi;
      logic signed [2*W:0] lo;
      hi = {{(W+2){1'b0}}, {(W-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         clip_fn = {1'b1, hi[W-1:0]};
      end else if (v < lo) begin
         clip_fn = {1'b1, lo[W-1:0]};
      end else begin
         clip_fn = {1'b0, v[W-1:0]};
      end
   endfunction

   // stage 1: products, add/sub, equality
   logic                  v1_ff;
   logic [CmdWidth-1:0]   cmd1_ff;
   logic signed [2*W-1:0] prr1_ff, pii1_ff, pri1_ff, pir1_ff, sqr1_ff, sqi1_ff;
   logic signed [W:0]     s_re1_ff, s_im1_ff, s_re1_in, s_im1_in;
   logic                  eq1_ff;

   always_comb begin
      if (cmd == CMD_SUB) begin
         s_re1_in = $signed({a_re[W-1], a_re}) - $signed({b_re[W-1], b_re});
         s_im1_in = $signed({a_im[W-1], a_im}) - $signed({b_im[W-1], b_im});
      end else begin
         s_re1_in = $signed({a_re[W-1], a_re}) + $signed({b_re[W-1], b_re});
         s_im1_in = $signed({a_im[W-1], a_im}) + $signed({b_im[W-1], b_im});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cmd1_ff  <= cmd;
         prr1_ff  <= a_re * b_re;
         pii1_ff  <= a_im * b_im;
         pri1_ff  <= a_re * b_im;
         pir1_ff  <= a_im * b_re;
         sqr1_ff  <= b_re * b_re;
         sqi1_ff  <= b_im * b_im;
         s_re1_ff <= s_re1_in;
         s_im1_ff <= s_im1_in;
         eq1_ff   <= (a_re == b_re) && (a_im == b_im);
      end
   end

   // stage 2: product sums and divisor
   logic                v2_ff;
   logic [CmdWidth-1:0] cmd2_ff;
   logic signed [2*W:0] mre2_ff, mim2_ff, nre2_ff, nim2_ff;
   logic [2*W-1:0]      den2_ff;
   logic signed [W:0]   s_re2_ff, s_im2_ff;
   logic                eq2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cmd2_ff  <= cmd1_ff;
         mre2_ff  <= prr1_ff - pii1_ff;
         mim2_ff  <= pri1_ff + pir1_ff;
         nre2_ff  <= prr1_ff + pii1_ff;
         nim2_ff  <= pir1_ff - pri1_ff;
         den2_ff  <= unsigned'(sqr1_ff) + unsigned'(sqi1_ff);
         s_re2_ff <= s_re1_ff;
         s_im2_ff <= s_im1_ff;
         eq2_ff   <= eq1_ff;
      end
   end

   // stage 3: rescale and clip simple results, prepare divider operands
   logic                v3_ff;
   ctl_type             ctl3_ff, ctl3_in;
   logic [W-1:0]        re3_ff, im3_ff, re3_in, im3_in;
   logic [NumWidth-1:0] nre3_ff, nim3_ff, nre3_in, nim3_in;
   logic [2*W-1:0]      den3_ff;
   logic signed [2*W:0] mre_sh, mim_sh, s_re_x, s_im_x;
   logic [W:0]          clip_re, clip_im;
   logic [2*W:0]        mag_re, mag_im;

   always_comb begin
      mre_sh  = mre2_ff >>> FRAC_BITS;
      mim_sh  = mim2_ff >>> FRAC_BITS;
      s_re_x  = s_re2_ff;
      s_im_x  = s_im2_ff;
      clip_re = '0;
      clip_im = '0;
      ctl3_in = '0;
      re3_in  = '0;
      im3_in  = '0;
      unique case (cmd2_ff)
         CMD_ADD, CMD_SUB: begin
            clip_re = clip_fn(s_re_x);
            clip_im = clip_fn(s_im_x);
         end
         CMD_MUL: begin
            clip_re = clip_fn(mre_sh);
            clip_im = clip_fn(mim_sh);
         end
         CMD_DIV: ctl3_in.is_div = 1'b1;
         CMD_EQ:  ctl3_in.compare_true = eq2_ff;
         CMD_NE:  ctl3_in.compare_true = !eq2_ff;
         default: ctl3_in = '0;
      endcase
      re3_in = clip_re[W-1:0];
      im3_in = clip_im[W-1:0];
      ctl3_in.saturated = clip_re[W] | clip_im[W];

      mag_re  = nre2_ff[2*W] ? unsigned'(-nre2_ff) : unsigned'(nre2_ff);
      mag_im  = nim2_ff[2*W] ? unsigned'(-nim2_ff) : unsigned'(nim2_ff);
      nre3_in = NumWidth'(mag_re) << FRAC_BITS;
      nim3_in = NumWidth'(mag_im) << FRAC_BITS;
      ctl3_in.neg_re   = nre2_ff[2*W];
      ctl3_in.neg_im   = nim2_ff[2*W];
      ctl3_in.div_zero = (den2_ff == '0);
      // quotient would need more than the divider's bits
      ctl3_in.ovf_re   = (nre3_in >> (W+1)) >= NumWidth'(den2_ff);
      ctl3_in.ovf_im   = (nim3_in >> (W+1)) >= NumWidth'(den2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (enable) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ctl3_ff <= ctl3_in;
         re3_ff  <= re3_in;
         im3_ff  <= im3_in;
         nre3_ff <= nre3_in;
         nim3_ff <= nim3_in;
         den3_ff <= den2_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign out_ctl    = ctl3_ff;
   assign out_re     = re3_ff;
   assign out_im     = im3_ff;
   assign out_num_re = nre3_ff;
   assign out_num_im = nim3_ff;
   assign out_den    = den3_ff;

endmodule
`default_nettype wire

// ===== rtl/cau_div_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div_pipe
// Pipelined restoring divider, one quotient bit per stage, real and
// imaginary quotients side by side; other results ride along unchanged.
// ----------------------------------------------------------------------------
module cau_div_pipe
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = DataWidthDef,
   parameter int FRAC_BITS  = FracBitsDef,
   localparam int NumWidth  = 2*DATA_WIDTH+1+FRAC_BITS,
   localparam int QWidth    = DATA_WIDTH+1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  ctl_type                 in_ctl,
   input  logic [DATA_WIDTH-1:0]   in_re,
   input  logic [DATA_WIDTH-1:0]   in_im,
   input  logic [NumWidth-1:0]     in_num_re,
   input  logic [NumWidth-1:0]     in_num_im,
   input  logic [2*DATA_WIDTH-1:0] in_den,
   output logic                    out_valid,
   output ctl_type                 out_ctl,
   output logic [DATA_WIDTH-1:0]   out_re,
   output logic [DATA_WIDTH-1:0]   out_im,
   output logic [QWidth-1:0]       out_q_re,
   output logic [QWidth-1:0]       out_q_im
);

   localparam int W        = DATA_WIDTH;
   localparam int Stages   = W+1;
   localparam int CmpWidth = 3*W+2;

   logic                v_ff   [Stages];
   ctl_type             ctl_ff [Stages];
   logic [W-1:0]        re_ff  [Stages];
   logic [W-1:0]        im_ff  [Stages];
   logic [NumWidth-1:0] nre_ff [Stages];
   logic [NumWidth-1:0] nim_ff [Stages];
   logic [2*W-1:0]      den_ff [Stages];
   logic [QWidth-1:0]   qre_ff [Stages];
   logic [QWidth-1:0]   qim_ff [Stages];

   for (genvar j = 0; j < Stages; j++) begin : g_stage
      localparam int Bit = W - j;

      logic                v_prev;
      ctl_type             ctl_prev;
      logic [W-1:0]        re_prev, im_prev;
      logic [NumWidth-1:0] nre_prev, nim_prev, nre_in, nim_in;
      logic [2*W-1:0]      den_prev;
      logic [QWidth-1:0]   qre_prev, qim_prev, qre_in, qim_in;
      logic [CmpWidth-1:0] dsh;
      logic                ge_re, ge_im;

      if (j == 0) begin : g_head
         assign v_prev   = in_valid;
         assign ctl_prev = in_ctl;
         assign re_prev  = in_re;
         assign im_prev  = in_im;
         assign nre_prev = in_num_re;
         assign nim_prev = in_num_im;
         assign den_prev = in_den;
         assign qre_prev = '0;
         assign qim_prev = '0;
      end else begin : g_link
         assign v_prev   = v_ff[j-1];
         assign ctl_prev = ctl_ff[j-1];
         assign re_prev  = re_ff[j-1];
         assign im_prev  = im_ff[j-1];
         assign nre_prev = nre_ff[j-1];
         assign nim_prev = nim_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign qre_prev = qre_ff[j-1];
         assign qim_prev = qim_ff[j-1];
      end

      always_comb begin
         dsh    = CmpWidth'(den_prev) << Bit;
         ge_re  = CmpWidth'(nre_prev) >= dsh;
         ge_im  = CmpWidth'(nim_prev) >= dsh;
         nre_in = ge_re ? NumWidth'(CmpWidth'(nre_prev) - dsh) : nre_prev;
         nim_in = ge_im ? NumWidth'(CmpWidth'(nim_prev) - dsh) : nim_prev;
         qre_in = qre_prev | (QWidth'(ge_re) << Bit);
         qim_in = qim_prev | (QWidth'(ge_im) << Bit);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (enable) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            ctl_ff[j] <= ctl_prev;
            re_ff[j]  <= re_prev;
            im_ff[j]  <= im_prev;
            nre_ff[j] <= nre_in;
            nim_ff[j] <= nim_in;
            den_ff[j] <= den_prev;
            qre_ff[j] <= qre_in;
            qim_ff[j] <= qim_in;
         end
      end
   end

   assign out_valid = v_ff[Stages-1];
   assign out_ctl   = ctl_ff[Stages-1];
   assign out_re    = re_ff[Stages-1];
   assign out_im    = im_ff[Stages-1];
   assign out_q_re  = qre_ff[Stages-1];
   assign out_q_im  = qim_ff[Stages-1];

endmodule
`default_nettype wire

// ===== rtl/complex_arithmetic_unit_core.sv =====
`default_nettype none
// Complex ALU on signed fixed point operands: add, subtract, multiply,
// divide, equal and not equal. One item enters per clock while the output
// is not stalled, and each item passes through three front stages for
// products, sums and scaling, DATA_WIDTH+1 divider stages that each
// resolve one quotient bit, and the output register. Every operation
// takes the same path, so results come out in order. A stalled output holds
// the whole pipeline, and the input is ready whenever the output register is
// empty or being taken.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Top level: stream ports, pipeline control, divider sign fix-up and output
// register.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = DataWidthDef,
   parameter int FRAC_BITS  = FracBitsDef,
   localparam int InBits    = CmdWidth + 4*DATA_WIDTH,
   localparam int InWidth   = ((InBits + 7) / 8) * 8,
   localparam int OutBits   = 2*DATA_WIDTH + 3,
   localparam int OutWidth  = ((OutBits + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // cmd, a_re, a_im, b_re, b_im (from bit 0 up), zero padded
   input  logic [InWidth-1:0]  req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // res_re, res_im, compare_true, div_zero, saturated (from bit 0 up), zero padded
   output logic [OutWidth-1:0] rsp_tdata
);

   localparam int W        = DATA_WIDTH;
   localparam int NumWidth = 2*W+1+FRAC_BITS;
   localparam int QWidth   = W+1;

   logic                enable;
   logic [CmdWidth-1:0] cmd;
   logic signed [W-1:0] a_re, a_im, b_re, b_im;

   logic                f_valid;
   ctl_type             f_ctl;
   logic [W-1:0]        f_re, f_im;
   logic [NumWidth-1:0] f_num_re, f_num_im;
   logic [2*W-1:0]      f_den;

   logic                d_valid;
   ctl_type             d_ctl;
   logic [W-1:0]        d_re, d_im;
   logic [QWidth-1:0]   d_q_re, d_q_im;

   logic                rsp_valid_ff;
   logic [W-1:0]        res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic                cmp_ff, dz_ff, sat_ff, cmp_in, dz_in, sat_in;
   logic [W:0]          div_re, div_im;

   assign enable     = !rsp_valid_ff || rsp_tready;
   assign req_tready = enable;

   assign cmd  = req_tdata[CmdWidth-1:0];
   assign a_re = req_tdata[CmdWidth       +: W];
   assign a_im = req_tdata[CmdWidth + W   +: W];
   assign b_re = req_tdata[CmdWidth + 2*W +: W];
   assign b_im = req_tdata[CmdWidth + 3*W +: W];

   cau_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (req_tvalid),
      .cmd        (cmd),
      .a_re       (a_re),
      .a_im       (a_im),
      .b_re       (b_re),
      .b_im       (b_im),
      .out_valid  (f_valid),
      .out_ctl    (f_ctl),
      .out_re     (f_re),
      .out_im     (f_im),
      .out_num_re (f_num_re),
      .out_num_im (f_num_im),
      .out_den    (f_den)
   );

   cau_div_pipe #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (f_valid),
      .in_ctl    (f_ctl),
      .in_re     (f_re),
      .in_im     (f_im),
      .in_num_re (f_num_re),
      .in_num_im (f_num_im),
      .in_den    (f_den),
      .out_valid (d_valid),
      .out_ctl   (d_ctl),
      .out_re    (d_re),
      .out_im    (d_im),
      .out_q_re  (d_q_re),
      .out_q_im  (d_q_im)
   );

   // signed quotient from magnitude, clipped; msb of result is the clip flag
   function automatic logic [W:0] quot_fn(input logic [QWidth-1:0] q, input logic neg,
                                          input logic ovf);
      logic [QWidth-1:0] pos_lim;
      logic [QWidth-1:0] neg_lim;
      logic [QWidth-1:0] q_neg;
      pos_lim = {2'b00, {(W-1){1'b1}}};
      neg_lim = {2'b01, {(W-1){1'b0}}};
      q_neg   = ~q + QWidth'(1);
      if (!neg) begin
         if (ovf || q > pos_lim) begin
            quot_fn = {1'b1, pos_lim[W-1:0]};
         end else begin
            quot_fn = {1'b0, q[W-1:0]};
         end
      end else begin
         if (ovf || q > neg_lim) begin
            quot_fn = {1'b1, neg_lim[W-1:0]};
         end else begin
            quot_fn = {1'b0, q_neg[W-1:0]};
         end
      end
   endfunction

   always_comb begin
      div_re = quot_fn(d_q_re, d_ctl.neg_re, d_ctl.ovf_re);
      div_im = quot_fn(d_q_im, d_ctl.neg_im, d_ctl.ovf_im);
      priority if (!d_ctl.is_div) begin
         res_re_in = d_re;
         res_im_in = d_im;
         cmp_in    = d_ctl.compare_true;
         dz_in     = 1'b0;
         sat_in    = d_ctl.saturated;
      end else if (d_ctl.div_zero) begin
         res_re_in = '0;
         res_im_in = '0;
         cmp_in    = 1'b0;
         dz_in     = 1'b1;
         sat_in    = 1'b0;
      end else begin
         res_re_in = div_re[W-1:0];
         res_im_in = div_im[W-1:0];
         cmp_in    = 1'b0;
         dz_in     = 1'b0;
         sat_in    = div_re[W] | div_im[W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         cmp_ff    <= cmp_in;
         dz_ff     <= dz_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OutWidth'({sat_ff, dz_ff, cmp_ff, res_im_ff, res_re_ff});

endmodule
`default_nettype wire

// ===== rtl/cau_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the complex ALU: reset, stall behavior and
// consistency of the result flags.
// ----------------------------------------------------------------------------
module cau_checker
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = DataWidthDef,
   localparam int OutBits   = 2*DATA_WIDTH + 3,
   localparam int OutWidth  = ((OutBits + 7) / 8) * 8
) (
   input logic                clock,
   input logic                reset,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [OutWidth-1:0] rsp_tdata
);

   localparam int W = DATA_WIDTH;

   logic cmp, dz, sat;

   assign cmp = rsp_tdata[2*W];
   assign dz  = rsp_tdata[2*W+1];
   assign sat = rsp_tdata[2*W+2];

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item taken while output stalled");

   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cmp |-> !dz && !sat && rsp_tdata[2*W-1:0] == '0)
      else $error("compare result carries other flags or data");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && dz |-> !sat && rsp_tdata[2*W-1:0] == '0)
      else $error("divide by zero result not cleared");

endmodule

bind complex_arithmetic_unit_core cau_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_cau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
